>>> design/bouncing_shadebob_renderer_unit_assert.svh
// Assertion macros for the bouncing shadebob renderer.
// Included by the top level; no other dependencies.
`ifndef BOUNCING_SHADEBOB_RENDERER_UNIT_ASSERT_SVH
`define BOUNCING_SHADEBOB_RENDERER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BSR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsr assertion failed");
`define BSR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsr assertion failed");
`else
`define BSR_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define BSR_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

>>> design/bsr_pkg.sv
// Shared types, codes and constants of the bouncing shadebob renderer.
// No dependencies.
package bsr_pkg;

    // Default geometry and sizes.
    localparam int FRAME_W_DEF   = 320;
    localparam int FRAME_H_DEF   = 200;
    localparam int MAX_BLOBS_DEF = 64;
    localparam int BOB_SIZE_DEF  = 64;
    localparam int FRAC_BITS_DEF = 8;

    // Operation codes carried in tuser.
    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_CLEAR  = 2'd1,
        FUNC_RENDER = 2'd2,
        FUNC_READ   = 2'd3
    } func_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_NUM_BLOBS = 3'd0;
    localparam logic [2:0] REG_X_MIN     = 3'd1;
    localparam logic [2:0] REG_X_MAX     = 3'd2;
    localparam logic [2:0] REG_Y_MIN     = 3'd3;
    localparam logic [2:0] REG_Y_MAX     = 3'd4;

    // Register reset values.
    localparam logic [6:0] NUM_BLOBS_RST = 7'd40;
    localparam logic [8:0] X_MIN_RST     = 9'd40;
    localparam logic [8:0] X_MAX_RST     = 9'd280;
    localparam logic [7:0] Y_MIN_RST     = 8'd40;
    localparam logic [7:0] Y_MAX_RST     = 8'd160;

    // Width of the position arithmetic, enough for the widest fraction.
    localparam int ARITH_W = 26;

    // Blob table word: {vel_y, vel_x, pos_y, pos_x}.
    localparam int BLOB_W = 17 + 16 + 10 + 10;

    // Negate a velocity; the most negative value maps to the largest.
    function automatic logic signed [9:0] neg_vel(input logic signed [9:0] v);
        logic signed [9:0] r;
        r = -v;
        if (v == -10'sd512) begin
            r = 10'sd511;
        end
        return r;
    endfunction

endpackage

>>> design/bsr_frame_mem.sv
// Frame store: one write port, one read port with registered data.
// Depends on nothing.
module bsr_frame_mem #(
    parameter int DEPTH  = 64000,
    parameter int ADDR_W = 16
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/bsr_blob_mem.sv
// Blob table: one write port, one registered read port, per-entry valid bits.
// Depends on bsr_pkg for the word width.
module bsr_blob_mem #(
    parameter int DEPTH  = 64,
    parameter int IDX_W  = 6
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [IDX_W-1:0]           wr_addr,
    input  logic [bsr_pkg::BLOB_W-1:0] wr_data,
    input  logic [IDX_W-1:0]           rd_addr,
    output logic [bsr_pkg::BLOB_W-1:0] rd_data
);

    logic [bsr_pkg::BLOB_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           valid_reg;
    logic [bsr_pkg::BLOB_W-1:0] q_reg;
    logic                       q_valid_reg;

    // Valid bits; an entry never written reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Storage and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        q_reg       <= mem[rd_addr];
        q_valid_reg <= valid_reg[rd_addr];
    end

    assign rd_data = q_valid_reg ? q_reg : '0;

endmodule

>>> design/bsr_stamp.sv
// Stamp pipeline: walks the kernel square, computes each kernel value and
// does a saturating read-modify-write on the frame store. Uses bsr_pkg only
// through its parent.
module bsr_stamp #(
    parameter int FRAME_W  = 320,
    parameter int FRAME_H  = 200,
    parameter int BOB_SIZE = 64,
    parameter int FA_W     = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [16:0]     cx,
    input  logic [16:0]     cy,
    output logic            busy,
    output logic [FA_W-1:0] rd_addr,
    input  logic [7:0]      rd_data,
    output logic            wr_en,
    output logic [FA_W-1:0] wr_addr,
    output logic [7:0]      wr_data
);

    localparam int HALF   = BOB_SIZE / 2;
    localparam int CW     = $clog2(BOB_SIZE);
    localparam int SW     = 19;
    localparam int SQ_W   = 2 * CW - 1;
    localparam int R_W    = 2 * CW;
    localparam int NUM_W  = R_W + 10;
    localparam int KR2    = HALF * HALF;
    localparam logic [63:0] KERN_M = ((64'd1 << 32) + 64'(KR2) - 64'd1) / 64'(KR2);
    localparam int M_W    = 27;

    localparam logic signed [SW-1:0] HALF_S = SW'(HALF);
    localparam logic signed [SW-1:0] FW_S   = SW'(FRAME_W);
    localparam logic signed [SW-1:0] FH_S   = SW'(FRAME_H);

    logic [CW-1:0] i_reg, j_reg;
    logic          issue_reg;
    logic [16:0]   cx_reg, cy_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic in1_reg, in2_reg, in3_reg, in4_reg, in5_reg;
    logic signed [SW-1:0] x1_reg, y1_reg;
    logic [SQ_W-1:0] dx2_1_reg, dy2_1_reg;
    logic [FA_W-1:0] a2_reg, a3_reg, a4_reg, a5_reg;
    logic [R_W-1:0]  r2_reg;
    logic [63:0]     prod3_reg;
    logic            ins3_reg;
    logic [9:0]      t4_reg;
    logic [7:0]      pix4_reg, pix5_reg;
    logic [19:0]     tt5_reg;

    logic signed [SW-1:0] x_c, y_c;
    logic signed [CW:0]   dx_c, dy_c;
    logic signed [2*CW+1:0] dxf_c, dyf_c;
    logic                 in_c;
    logic [SW-1:0]        xu1, yu1;
    logic [NUM_W-1:0]     num3;
    logic [7:0]           kval;
    logic [8:0]           sum5;

    // Pixel walk: one kernel cell per cycle, row by row.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
        end else if (start) begin
            issue_reg <= 1'b1;
            i_reg     <= '0;
            j_reg     <= '0;
            cx_reg    <= cx;
            cy_reg    <= cy;
        end else if (issue_reg) begin
            i_reg <= i_reg + 1'b1;
            if (i_reg == CW'(BOB_SIZE - 1)) begin
                j_reg <= j_reg + 1'b1;
                if (j_reg == CW'(BOB_SIZE - 1)) begin
                    issue_reg <= 1'b0;
                end
            end
        end
    end

    // Cell coordinates, clip test and squared offsets.
    always_comb begin
        x_c   = $signed(SW'(cx_reg)) + $signed(SW'(i_reg)) - HALF_S;
        y_c   = $signed(SW'(cy_reg)) + $signed(SW'(j_reg)) - HALF_S;
        in_c  = (x_c >= 0) && (x_c < FW_S) && (y_c >= 0) && (y_c < FH_S);
        dx_c  = $signed({1'b0, i_reg}) - $signed((CW + 1)'(HALF));
        dy_c  = $signed({1'b0, j_reg}) - $signed((CW + 1)'(HALF));
        dxf_c = dx_c * dx_c;
        dyf_c = dy_c * dy_c;
    end

    assign xu1  = x1_reg;
    assign yu1  = y1_reg;
    assign num3 = (NUM_W'(r2_reg) << 10) - NUM_W'(r2_reg);

    // Valid bits of the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v1_reg <= issue_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Datapath stages: address and radius, reciprocal product, kernel base,
    // square, then saturating add.
    always_ff @(posedge aclk) begin
        in1_reg   <= in_c;
        x1_reg    <= x_c;
        y1_reg    <= y_c;
        dx2_1_reg <= dxf_c[SQ_W-1:0];
        dy2_1_reg <= dyf_c[SQ_W-1:0];

        in2_reg   <= in1_reg;
        a2_reg    <= in1_reg ? FA_W'(yu1 * FRAME_W + xu1) : '0;
        r2_reg    <= R_W'(dx2_1_reg) + R_W'(dy2_1_reg);

        in3_reg   <= in2_reg;
        a3_reg    <= a2_reg;
        ins3_reg  <= r2_reg < R_W'(KR2);
        prod3_reg <= 64'(num3) * 64'(KERN_M[M_W-1:0]);

        in4_reg   <= in3_reg;
        a4_reg    <= a3_reg;
        t4_reg    <= ins3_reg ? (10'd1023 - prod3_reg[32 +: 10]) : 10'd0;
        pix4_reg  <= rd_data;

        in5_reg   <= in4_reg;
        a5_reg    <= a4_reg;
        tt5_reg   <= t4_reg * t4_reg;
        pix5_reg  <= pix4_reg;
    end

    // Kernel value and saturating add.
    assign kval = {tt5_reg[19:13], 1'b0};
    assign sum5 = {1'b0, pix5_reg} + {1'b0, kval};

    assign rd_addr = a2_reg;
    assign wr_en   = v5_reg & in5_reg;
    assign wr_addr = a5_reg;
    assign wr_data = sum5[8] ? 8'd255 : sum5[7:0];
    assign busy    = issue_reg | v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;

endmodule

>>> design/bouncing_shadebob_renderer_unit.sv
// Top level of the bouncing shadebob renderer: sequencer, blob motion unit,
// configuration registers. Depends on bsr_pkg, bsr_frame_mem, bsr_blob_mem,
// bsr_stamp and the assertion header.
//
//  Channel  Direction  Signals                         Contents
//  s_       in         s_tvalid s_tready s_tdata s_tuser  one operation word
//  m_       out        m_tvalid m_tready m_tdata m_tuser  one result word
//  cfg_     in         cfg_we cfg_addr cfg_wdata          register writes
//
// Load writes the blob table on acceptance and read fetches one frame-store
// pixel. Clear zeroes every pixel, one frame-store write per cycle. Render moves
// and stamps each active blob in turn, with a single frame-store read-modify-write
// per cycle in the stamp pipeline. After reset a clearing pass over all
// FRAME_W*FRAME_H pixels runs with s_tready low. A result
// waiting on m_tready holds the block before it returns to idle.
`include "bouncing_shadebob_renderer_unit_assert.svh"
module bouncing_shadebob_renderer_unit #(
    parameter int FRAME_W   = bsr_pkg::FRAME_W_DEF,
    parameter int FRAME_H   = bsr_pkg::FRAME_H_DEF,
    parameter int MAX_BLOBS = bsr_pkg::MAX_BLOBS_DEF,
    parameter int BOB_SIZE  = bsr_pkg::BOB_SIZE_DEF,
    parameter int FRAC_BITS = bsr_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // blob_index[5:0], start_x[22:6], start_y[38:23], speed_x[48:39],
    // speed_y[58:49], pixel_addr[74:59], zero fill [79:75]
    input  logic [79:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_value[7:0]
    output logic [7:0]  m_tdata,
    // op_done[1:0]
    output logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [8:0]  cfg_wdata
);

    localparam int FSIZE = FRAME_W * FRAME_H;
    localparam int FA_W  = $clog2(FSIZE);
    localparam int IDX_W = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
    localparam int K_W   = $clog2(MAX_BLOBS + 1);
    localparam int AW    = bsr_pkg::ARITH_W;
    localparam logic signed [AW-1:0] LIM_X = AW'(131071);
    localparam logic signed [AW-1:0] LIM_Y = AW'(65535);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_READ_DATA, ST_FETCH, ST_FETCH_WAIT,
        ST_ADD, ST_HI, ST_LO, ST_SAT, ST_WB, ST_STAMP, ST_FINISH
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [6:0] num_blobs_reg;
    logic [8:0] x_min_reg, x_max_reg;
    logic [7:0] y_min_reg, y_max_reg;

    // Sequencer registers.
    logic                 report_reg;
    bsr_pkg::func_t       func_reg;
    logic [7:0]           pix_reg;
    logic [FA_W-1:0]      clr_cnt_reg;
    logic [FA_W-1:0]      raddr_reg;
    logic                 rok_reg;
    logic [K_W-1:0]       k_reg, n_reg;
    logic                 axis_reg;
    logic [16:0]          px_reg;
    logic [15:0]          py_reg;
    logic signed [9:0]    vx_reg, vy_reg;
    logic signed [AW-1:0] p_reg;
    logic                 m_tvalid_reg;
    logic [7:0]           m_tdata_reg;
    logic [1:0]           m_tuser_reg;

    // Input fields.
    logic [5:0]        in_idx;
    logic [16:0]       in_sx;
    logic [15:0]       in_sy;
    logic [9:0]        in_vx, in_vy;
    logic [15:0]       in_addr;
    bsr_pkg::func_t    in_func;

    assign in_idx  = s_tdata[5:0];
    assign in_sx   = s_tdata[22:6];
    assign in_sy   = s_tdata[38:23];
    assign in_vx   = s_tdata[48:39];
    assign in_vy   = s_tdata[58:49];
    assign in_addr = s_tdata[74:59];
    assign in_func = bsr_pkg::func_t'(s_tuser);

    logic s_acc;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // Blob table wiring.
    logic                       bm_we;
    logic [IDX_W-1:0]           bm_waddr;
    logic [bsr_pkg::BLOB_W-1:0] bm_wdata, bm_rdata;

    // Frame store wiring.
    logic            fm_we;
    logic [FA_W-1:0] fm_waddr, fm_raddr;
    logic [7:0]      fm_wdata, fm_rdata;

    // Stamp wiring.
    logic            stp_start, stp_busy, stp_we;
    logic [FA_W-1:0] stp_raddr, stp_waddr;
    logic [7:0]      stp_wdata;

    // Motion unit: one shared adder/subtractor plus the bounce and clamp comparisons.
    logic signed [AW-1:0] cur_pos, cur_vel, lo_fx, hi_fx, lim_fx;
    logic signed [AW-1:0] alu_a, alu_b, alu_y;
    logic                 alu_sub;
    logic signed [9:0]    cur_v;

    assign cur_v   = axis_reg ? vy_reg : vx_reg;
    assign cur_pos = axis_reg ? $signed(AW'(py_reg)) : $signed(AW'(px_reg));
    assign cur_vel = AW'(cur_v);
    assign lo_fx   = axis_reg ? $signed(AW'(y_min_reg) << FRAC_BITS)
                              : $signed(AW'(x_min_reg) << FRAC_BITS);
    assign hi_fx   = axis_reg ? $signed(AW'(y_max_reg) << FRAC_BITS)
                              : $signed(AW'(x_max_reg) << FRAC_BITS);
    assign lim_fx  = axis_reg ? LIM_Y : LIM_X;

    // Operand selection per sequencer step.
    always_comb begin
        alu_a   = cur_pos;
        alu_b   = cur_vel;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_HI: begin
                alu_a   = hi_fx <<< 1;
                alu_b   = p_reg;
                alu_sub = 1'b1;
            end
            ST_LO: begin
                alu_a   = lo_fx <<< 1;
                alu_b   = p_reg;
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = cur_pos;
                alu_b   = cur_vel;
                alu_sub = 1'b0;
            end
        endcase
        alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    // Saturated position of the current axis.
    logic signed [AW-1:0] p_sat;
    always_comb begin
        p_sat = p_reg;
        if (p_reg < 0) begin
            p_sat = '0;
        end else if (p_reg > lim_fx) begin
            p_sat = lim_fx;
        end
    end

    // Blob count clamped to the table size.
    logic [K_W-1:0] n_c;
    assign n_c = (32'(num_blobs_reg) > MAX_BLOBS) ? K_W'(MAX_BLOBS) : K_W'(num_blobs_reg);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_blobs_reg <= bsr_pkg::NUM_BLOBS_RST;
            x_min_reg     <= bsr_pkg::X_MIN_RST;
            x_max_reg     <= bsr_pkg::X_MAX_RST;
            y_min_reg     <= bsr_pkg::Y_MIN_RST;
            y_max_reg     <= bsr_pkg::Y_MAX_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                bsr_pkg::REG_NUM_BLOBS: num_blobs_reg <= cfg_wdata[6:0];
                bsr_pkg::REG_X_MIN:     x_min_reg     <= cfg_wdata;
                bsr_pkg::REG_X_MAX:     x_max_reg     <= cfg_wdata;
                bsr_pkg::REG_Y_MIN:     y_min_reg     <= cfg_wdata[7:0];
                bsr_pkg::REG_Y_MAX:     y_max_reg     <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Sequencer and output word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            report_reg   <= 1'b0;
            clr_cnt_reg  <= '0;
            k_reg        <= '0;
            axis_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // The finish step loads the next word itself.
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == FA_W'(FSIZE - 1)) begin
                        clr_cnt_reg <= '0;
                        state_reg   <= report_reg ? ST_FINISH : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_acc) begin
                        func_reg  <= in_func;
                        pix_reg   <= '0;
                        raddr_reg <= FA_W'(in_addr);
                        rok_reg   <= 32'(in_addr) < FSIZE;
                        k_reg     <= '0;
                        n_reg     <= n_c;
                        axis_reg  <= 1'b0;
                        unique case (in_func)
                            bsr_pkg::FUNC_LOAD: state_reg <= ST_FINISH;
                            bsr_pkg::FUNC_CLEAR: begin
                                report_reg <= 1'b1;
                                state_reg  <= ST_CLEAR;
                            end
                            bsr_pkg::FUNC_RENDER:
                                state_reg <= (n_c == '0) ? ST_FINISH : ST_FETCH;
                            bsr_pkg::FUNC_READ: state_reg <= ST_READ;
                            default: state_reg <= ST_FINISH;
                        endcase
                    end
                end
                ST_READ: state_reg <= ST_READ_DATA;
                ST_READ_DATA: begin
                    pix_reg   <= rok_reg ? fm_rdata : 8'd0;
                    state_reg <= ST_FINISH;
                end
                ST_FETCH: state_reg <= ST_FETCH_WAIT;
                ST_FETCH_WAIT: begin
                    px_reg    <= bm_rdata[16:0];
                    py_reg    <= bm_rdata[32:17];
                    vx_reg    <= $signed(bm_rdata[42:33]);
                    vy_reg    <= $signed(bm_rdata[52:43]);
                    axis_reg  <= 1'b0;
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    p_reg     <= alu_y;
                    state_reg <= ST_HI;
                end
                ST_HI: begin
                    if (p_reg >= hi_fx) begin
                        p_reg <= alu_y;
                        if (axis_reg) vy_reg <= bsr_pkg::neg_vel(vy_reg);
                        else          vx_reg <= bsr_pkg::neg_vel(vx_reg);
                    end
                    state_reg <= ST_LO;
                end
                ST_LO: begin
                    if (p_reg < lo_fx) begin
                        p_reg <= alu_y;
                        if (axis_reg) vy_reg <= bsr_pkg::neg_vel(vy_reg);
                        else          vx_reg <= bsr_pkg::neg_vel(vx_reg);
                    end
                    state_reg <= ST_SAT;
                end
                ST_SAT: begin
                    if (axis_reg) begin
                        py_reg    <= p_sat[15:0];
                        state_reg <= ST_WB;
                    end else begin
                        px_reg    <= p_sat[16:0];
                        axis_reg  <= 1'b1;
                        state_reg <= ST_ADD;
                    end
                end
                ST_WB: state_reg <= ST_STAMP;
                ST_STAMP: begin
                    if (!stp_busy) begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= (k_reg + 1'b1 == n_reg) ? ST_FINISH : ST_FETCH;
                    end
                end
                ST_FINISH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= pix_reg;
                        m_tuser_reg  <= func_reg;
                        report_reg   <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Blob table port selection: load on accept, write-back after motion.
    logic load_we;
    assign load_we  = s_acc && (in_func == bsr_pkg::FUNC_LOAD) && (32'(in_idx) < MAX_BLOBS);
    assign bm_we    = load_we || (state_reg == ST_WB);
    assign bm_waddr = load_we ? IDX_W'(in_idx) : k_reg[IDX_W-1:0];
    assign bm_wdata = load_we ? {in_vy, in_vx, in_sy, in_sx}
                              : {vy_reg, vx_reg, py_reg, px_reg};

    bsr_blob_mem #(
        .DEPTH (MAX_BLOBS),
        .IDX_W (IDX_W)
    ) u_blob_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (bm_we),
        .wr_addr (bm_waddr),
        .wr_data (bm_wdata),
        .rd_addr (k_reg[IDX_W-1:0]),
        .rd_data (bm_rdata)
    );

    // Stamp starts on write-back, centered on the whole-pixel position.
    assign stp_start = (state_reg == ST_WB);

    bsr_stamp #(
        .FRAME_W  (FRAME_W),
        .FRAME_H  (FRAME_H),
        .BOB_SIZE (BOB_SIZE),
        .FA_W     (FA_W)
    ) u_stamp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (stp_start),
        .cx      (px_reg >> FRAC_BITS),
        .cy      (17'(py_reg) >> FRAC_BITS),
        .busy    (stp_busy),
        .rd_addr (stp_raddr),
        .rd_data (fm_rdata),
        .wr_en   (stp_we),
        .wr_addr (stp_waddr),
        .wr_data (stp_wdata)
    );

    // Frame store port selection.
    logic clr_we;
    assign clr_we   = (state_reg == ST_CLEAR);
    assign fm_we    = clr_we || stp_we;
    assign fm_waddr = clr_we ? clr_cnt_reg : stp_waddr;
    assign fm_wdata = clr_we ? 8'd0 : stp_wdata;
    assign fm_raddr = (state_reg == ST_READ) ? raddr_reg : stp_raddr;

    bsr_frame_mem #(
        .DEPTH  (FSIZE),
        .ADDR_W (FA_W)
    ) u_frame_mem (
        .aclk    (aclk),
        .wr_en   (fm_we),
        .wr_addr (fm_waddr),
        .wr_data (fm_wdata),
        .rd_addr (fm_raddr),
        .rd_data (fm_rdata)
    );

    // The clear sweep and the stamp never write in the same cycle.
    `BSR_ASSERT_IMP(a_one_writer, aclk, aresetn, clr_we, !stp_we)
    // The stamp pipeline only runs while the sequencer waits on it.
    `BSR_ASSERT_IMP(a_stamp_owned, aclk, aresetn, stp_busy, (state_reg == ST_STAMP) || (state_reg == ST_WB))
    // An accepted word makes the block busy in the next cycle.
    `BSR_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_acc, !s_tready)

endmodule
